// File: hdl/linear_probe_hash_table_macros.svh
// assertion macros for the linear probe hash table
// used by lpht_ctrl, depends on nothing
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// same-cycle implication
`define LPHT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lpht_pkg.sv
// shared constants, codes and control structs for the linear probe hash table
// no dependencies
package lpht_pkg;

  localparam int TABLE_SIZE  = 128;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int KEY_W       = 31;
  localparam int LIMIT_W     = 8;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_MISSING   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_HOME,
    S_PROBE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    hash;
    logic    home;
    logic    advance;
    logic    write_slot;
    logic    clear_slot;
    logic    emit;
    status_t code;
    logic    show_slot;
    logic    show_key;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             used;
    logic             match;
    logic             last;
    logic             out_free;
  } stat_t;

endpackage

// File: hdl/lpht_ifs.sv
// request and response channel interfaces
// depends on lpht_pkg
interface lpht_req_if;
  import lpht_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [KEY_W-1:0]         key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface lpht_rsp_if;
  import lpht_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [IDX_W-1:0]         slot_index;
  logic [KEY_W-1:0]         key_out;

  modport source (output valid, output status, output slot_index, output key_out,
                  input ready);
  modport sink   (input valid, input status, input slot_index, input key_out,
                  output ready);
endinterface

// File: hdl/lpht_datapath.sv
// datapath: request registers, home slot hash, key memory, occupied bits,
// probe index and response register; depends on lpht_pkg
module lpht_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [lpht_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  logic [lpht_pkg::CMD_W-1:0]     req_command,
  input  logic [lpht_pkg::KEY_W-1:0]     req_key,
  input  lpht_pkg::ctrl_t                ctrl,
  output lpht_pkg::stat_t                stat,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [lpht_pkg::STATUS_W-1:0]  rsp_status,
  output logic [lpht_pkg::IDX_W-1:0]     rsp_slot_index,
  output logic [lpht_pkg::KEY_W-1:0]     rsp_key_out
);
  import lpht_pkg::*;

  localparam int DIGITS = (KEY_W + 2) / 3;

  logic [LIMIT_W-1:0]  table_limit;
  logic [LIMIT_W-1:0]  lim_eff;
  logic [CMD_W-1:0]    cmd;
  logic [KEY_W-1:0]    key;
  logic [6:0]          digsum;
  logic [2:0]          home;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    idx_next;
  logic [TABLE_SIZE-1:0] used;
  logic [KEY_W-1:0]    mem [TABLE_SIZE];
  logic [KEY_W-1:0]    rdata;

  // 8 = 1 mod 7, so the octal digit sum keeps the residue
  function automatic logic [6:0] digit_sum(input logic [KEY_W-1:0] k);
    logic [3*DIGITS-1:0] kx;
    logic [6:0]          s;
    kx = (3*DIGITS)'(k);
    s  = '0;
    for (int i = 0; i < DIGITS; i++) begin
      s = s + 7'(kx[3*i +: 3]);
    end
    return s;
  endfunction

  function automatic logic [2:0] mod7(input logic [6:0] d);
    logic [3:0] s2;
    logic [3:0] s3;
    s2 = 4'(d[6]) + 4'(d[5:3]) + 4'(d[2:0]);
    s3 = 4'(s2[3]) + 4'(s2[2:0]);
    return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
  endfunction

  assign home    = mod7(digsum);
  assign lim_eff = (table_limit > LIMIT_W'(TABLE_SIZE)) ? LIMIT_W'(TABLE_SIZE) : table_limit;

  always_comb begin
    if (ctrl.home) begin
      idx_next = IDX_W'(home);
    end else if (ctrl.advance) begin
      idx_next = idx + 1'b1;
    end else begin
      idx_next = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      table_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd <= req_command;
      key <= req_key;
    end
    if (ctrl.hash) begin
      digsum <= digit_sum(key);
    end
    idx <= idx_next;
  end

  // key memory, one write port and one read port, registered read
  always_ff @(posedge clk) begin
    if (ctrl.write_slot) begin
      mem[idx] <= key;
    end
    rdata <= mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ctrl.write_slot) begin
      used[idx] <= 1'b1;
    end else if (ctrl.clear_slot) begin
      used[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      rsp_status     <= ctrl.code;
      rsp_slot_index <= ctrl.show_slot ? idx : '0;
      rsp_key_out    <= ctrl.show_key ? rdata : '0;
    end
  end

  assign stat.cmd      = cmd;
  assign stat.used     = used[idx];
  assign stat.match    = (rdata == key);
  assign stat.last     = ((LIMIT_W'(idx) + LIMIT_W'(1)) >= lim_eff);
  assign stat.out_free = !rsp_valid || rsp_ready;

endmodule

// File: hdl/lpht_ctrl.sv
// controller state machine for insert, search and remove requests
// depends on lpht_pkg and linear_probe_hash_table_macros.svh
module lpht_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  lpht_pkg::stat_t  stat,
  output lpht_pkg::ctrl_t  ctrl
);
  import lpht_pkg::*;
  `include "linear_probe_hash_table_macros.svh"

  state_t  state;
  state_t  state_next;
  logic    finish;
  status_t code;
  logic    show_slot;
  logic    show_key;
  logic    do_write;
  logic    do_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // probe decision for the slot at the current index
  always_comb begin
    finish    = 1'b0;
    code      = ST_MISSING;
    show_slot = 1'b0;
    show_key  = 1'b0;
    do_write  = 1'b0;
    do_clear  = 1'b0;
    case (stat.cmd)
      CMD_INSERT: begin
        if (!stat.used) begin
          finish    = 1'b1;
          code      = ST_DONE;
          show_slot = 1'b1;
          do_write  = 1'b1;
        end else if (stat.match) begin
          finish = 1'b1;
          code   = ST_DUPLICATE;
        end else if (stat.last) begin
          finish = 1'b1;
          code   = ST_FULL;
        end
      end
      CMD_SEARCH, CMD_REMOVE: begin
        if (stat.used && stat.match) begin
          finish    = 1'b1;
          code      = ST_DONE;
          show_slot = 1'b1;
          show_key  = 1'b1;
          do_clear  = (stat.cmd == CMD_REMOVE);
        end else if (stat.last) begin
          finish = 1'b1;
          code   = ST_MISSING;
        end
      end
      default: begin
        finish = 1'b1;
        code   = ST_MISSING;
      end
    endcase
  end

  always_comb begin
    ctrl       = '0;
    ctrl.code  = code;
    state_next = state;
    req_ready  = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        ctrl.hash  = 1'b1;
        state_next = S_HOME;
      end
      S_HOME: begin
        ctrl.home  = 1'b1;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        if (!finish) begin
          ctrl.advance = 1'b1;
        end else if (stat.out_free) begin
          ctrl.emit       = 1'b1;
          ctrl.show_slot  = show_slot;
          ctrl.show_key   = show_key;
          ctrl.write_slot = do_write;
          ctrl.clear_slot = do_clear;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `LPHT_ASSERT_NEXT(a_accept_to_hash, clk, rst, (state == S_IDLE) && req_valid, state == S_HASH, "request accept did not start hashing")
  `LPHT_ASSERT_IMP(a_emit_free, clk, rst, ctrl.emit, stat.out_free, "response emitted over a pending one")
  `LPHT_ASSERT_IMP(a_write_free, clk, rst, ctrl.write_slot, !stat.used && (stat.cmd == CMD_INSERT), "insert wrote an occupied slot")
  `LPHT_ASSERT_IMP(a_clear_hit, clk, rst, ctrl.clear_slot, stat.used && stat.match && (stat.cmd == CMD_REMOVE), "remove freed a slot that did not match")

endmodule

// File: hdl/linear_probe_hash_table.sv
// One request (insert, search or remove of a 31-bit key) is taken at a time; its home slot
// is key mod 7 and probing runs forward, without wrap, to min(table_limit, 128). A request
// passes through latching, hashing and the start of the first key memory read, then
// examines one slot per cycle through the single read port of the key memory. The
// response sits in an output register, so a new request is taken while the previous
// response waits; a finished request holds on its last slot while that previous
// response is still not taken. Occupied marks clear at reset with no sweep;
// table_limit resets to 128.
// depends on lpht_pkg, lpht_ifs, lpht_ctrl, lpht_datapath
module linear_probe_hash_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lpht_pkg::LIMIT_W-1:0]  cfg_wr_data,
  lpht_req_if.sink                      req,
  lpht_rsp_if.source                    rsp
);
  import lpht_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  lpht_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .req_command    (req.command),
    .req_key        (req.key),
    .ctrl           (ctrl),
    .stat           (stat),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_slot_index (rsp.slot_index),
    .rsp_key_out    (rsp.key_out)
  );

endmodule
